FILE: rtl/lmbcm_pkg.sv
package lmbcm_pkg;

    localparam int RGB_W      = 24;
    localparam int CH_W       = 8;
    localparam int PLANE_W    = 3;
    localparam int TIMER_W    = 24;
    localparam int BASE_W     = 16;
    localparam int SCAN_W     = 2;
    localparam int POSITIONS  = 16;
    localparam int SCAN_LINES = 4;
    localparam int ROW_ADDR_W = 4;

    localparam logic [BASE_W-1:0] BASE_ON_RESET = 16'd5;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [2:0] {
        PH_SHIFT = 3'b001,
        PH_LATCH = 3'b010,
        PH_SHOW  = 3'b100
    } phase_t;

endpackage

FILE: rtl/lmbcm_frame_store.sv
module lmbcm_frame_store
    import lmbcm_pkg::*;
#(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [RGB_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [RGB_W-1:0]  rd_data
);

    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read, so a stalled result stays put
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/led_matrix_bcm_scan_driver.sv
// Quarter-scan RGB LED panel driver, binary code modulation.
// Input channel (in_valid/in_stall): each request is either a pixel write
// (req_type = 0: pix_x, pix_y, pix_rgb) or one refresh tick (req_type = 1).
// A pixel write produces nothing; a tick produces one pin vector on the
// output channel (out_valid/out_stall).
// A tick's pin vector is registered and valid in the cycle after the request is taken.
// Throughput: one request per clock while in_stall is low; the frame store has
// one write port and one registered read port, and each tick does a single read.
// Per scan row, half and plane the sequence is 16*SEGMENTS shift ticks,
// one latch tick, then base_on_time*2^plane display ticks.
// Reset: the frame store's 128*SEGMENTS entries (512 by default) are zeroed one
// entry per clock, with in_stall held high; cfg writes are taken throughout.
// Output stall: the pin vector holds, and in_stall rises until it is taken.
// base_on_time (cfg_data) takes effect on the next tick; 0 acts as 1.
module led_matrix_bcm_scan_driver
    import lmbcm_pkg::*;
#(
    parameter int SEGMENTS = 4,
    parameter int PLANES   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [BASE_W-1:0]     cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [4:0]            pix_x,
    input  logic [3:0]            pix_y,
    input  logic [RGB_W-1:0]      pix_rgb,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ROW_ADDR_W-1:0] row_addr,
    output logic                  red_top,
    output logic                  green_top,
    output logic                  blue_top,
    output logic                  red_bottom,
    output logic                  green_bottom,
    output logic                  blue_bottom,
    output logic                  shift_clock,
    output logic                  latch_strobe,
    output logic                  display_on
);

    localparam int COLUMNS = POSITIONS * SEGMENTS;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int DEPTH   = COLUMNS * SCAN_LINES * 2;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int X_LIMIT = 8 * SEGMENTS;

    logic [BASE_W-1:0]  base_on_reg;
    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    logic [SCAN_W-1:0]  scan_row_reg, scan_row_next;
    logic               half_sel_reg, half_sel_next;
    logic [PLANE_W-1:0] bit_plane_reg, bit_plane_next;
    logic [COL_W-1:0]   column_count_reg, column_count_next;
    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] on_timer_reg, on_timer_next;

    logic               out_valid_reg;
    logic [SCAN_W-1:0]  o_row_reg;
    logic               o_half_reg;
    logic [PLANE_W-1:0] o_plane_reg;
    phase_t             o_phase_reg;

    logic               accept;
    logic               tick_acc;
    logic               pix_acc;
    logic               x_ok;
    logic [ADDR_W-1:0]  pix_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [RGB_W-1:0]   mem_wdata;
    logic [RGB_W-1:0]   rd_data;
    logic [BASE_W-1:0]  base_eff;
    logic [TIMER_W-1:0] on_limit;
    logic [TIMER_W-1:0] timer_inc;
    logic               bit_r, bit_g, bit_b;
    logic               is_shift;

    assign cfg_ready = 1'b1;

    assign in_stall = clearing_reg || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign tick_acc = accept && (req_type == REQ_TICK);
    assign x_ok     = {27'd0, pix_x} < 32'(X_LIMIT);
    assign pix_acc  = accept && (req_type == REQ_PIXEL) && x_ok;

    // position = x mod 8 + 8*(row group parity); then column group; then scan/half row
    assign pix_addr = ADDR_W'({pix_y[2], pix_x[2:0]})
                    + (ADDR_W'(pix_x[4:3]) << 4)
                    + ADDR_W'(COLUMNS) * ADDR_W'({pix_y[3], pix_y[1:0]});

    assign rd_addr = ADDR_W'(column_count_reg)
                   + ADDR_W'(COLUMNS) * ADDR_W'({half_sel_reg, scan_row_reg});

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = pix_acc;
            mem_waddr = pix_addr;
            mem_wdata = pix_rgb;
        end
    end

    lmbcm_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (tick_acc),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign base_eff  = (base_on_reg == '0) ? BASE_W'(1) : base_on_reg;
    assign on_limit  = TIMER_W'(base_eff) << bit_plane_reg;
    assign timer_inc = on_timer_reg + TIMER_W'(1);

    always_comb
    begin
        scan_row_next     = scan_row_reg;
        half_sel_next     = half_sel_reg;
        bit_plane_next    = bit_plane_reg;
        column_count_next = column_count_reg;
        phase_next        = phase_reg;
        on_timer_next     = on_timer_reg;
        if (tick_acc)
        begin
            case (phase_reg)
                PH_SHIFT:
                begin
                    if (column_count_reg == COL_W'(COLUMNS - 1))
                    begin
                        column_count_next = '0;
                        phase_next        = PH_LATCH;
                    end
                    else
                    begin
                        column_count_next = column_count_reg + COL_W'(1);
                    end
                end
                PH_LATCH:
                begin
                    on_timer_next = '0;
                    phase_next    = PH_SHOW;
                end
                PH_SHOW:
                begin
                    if (timer_inc >= on_limit)
                    begin
                        on_timer_next = '0;
                        phase_next    = PH_SHIFT;
                        // plane fastest, then half, then scan row
                        if (bit_plane_reg == PLANE_W'(PLANES - 1))
                        begin
                            bit_plane_next = '0;
                            half_sel_next  = !half_sel_reg;
                            if (half_sel_reg)
                            begin
                                scan_row_next = scan_row_reg + SCAN_W'(1);
                            end
                        end
                        else
                        begin
                            bit_plane_next = bit_plane_reg + PLANE_W'(1);
                        end
                    end
                    else
                    begin
                        on_timer_next = timer_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_SHIFT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_on_reg      <= BASE_ON_RESET;
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            scan_row_reg     <= '0;
            half_sel_reg     <= 1'b0;
            bit_plane_reg    <= '0;
            column_count_reg <= '0;
            phase_reg        <= PH_SHIFT;
            on_timer_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_on_reg <= cfg_data;
            end
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            scan_row_reg     <= scan_row_next;
            half_sel_reg     <= half_sel_next;
            bit_plane_reg    <= bit_plane_next;
            column_count_reg <= column_count_next;
            phase_reg        <= phase_next;
            on_timer_reg     <= on_timer_next;
            if (tick_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // tick context for the output stage; pairs with the registered read data
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            o_row_reg   <= scan_row_reg;
            o_half_reg  <= half_sel_reg;
            o_plane_reg <= bit_plane_reg;
            o_phase_reg <= phase_reg;
        end
    end

    assign is_shift = (o_phase_reg == PH_SHIFT);
    assign bit_r    = rd_data[5'(o_plane_reg)];
    assign bit_g    = rd_data[5'(o_plane_reg) + 5'(CH_W)];
    assign bit_b    = rd_data[5'(o_plane_reg) + 5'(2 * CH_W)];

    assign out_valid    = out_valid_reg;
    assign row_addr     = ROW_ADDR_W'(o_row_reg);
    assign red_top      = is_shift && !o_half_reg && bit_r;
    assign green_top    = is_shift && !o_half_reg && bit_g;
    assign blue_top     = is_shift && !o_half_reg && bit_b;
    assign red_bottom   = is_shift && o_half_reg && bit_r;
    assign green_bottom = is_shift && o_half_reg && bit_g;
    assign blue_bottom  = is_shift && o_half_reg && bit_b;
    assign shift_clock  = is_shift;
    assign latch_strobe = (o_phase_reg == PH_LATCH);
    assign display_on   = (o_phase_reg == PH_SHOW);

endmodule

FILE: tb/sv/tb_led_matrix_bcm_scan_driver.sv
`timescale 1ns / 100ps

module tb_led_matrix_bcm_scan_driver
    import lmbcm_pkg::*;
();

    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [3:0] row;
        logic       r_t;
        logic       g_t;
        logic       b_t;
        logic       r_b;
        logic       g_b;
        logic       b_b;
        logic       shift;
        logic       latch;
        logic       disp;
    } pins_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  x;
        logic [3:0]  y;
        logic [23:0] rgb;
        logic        typed;
        pins_t       pins;
    } step_row_t;

    localparam pins_t NO_PINS     = '0;
    localparam pins_t BLANK_SHIFT = {4'd0, 6'b000000, 3'b100};
    localparam pins_t RED_SHIFT   = {4'd0, 6'b100000, 3'b100};
    localparam pins_t GREEN_SHIFT = {4'd0, 6'b010000, 3'b100};
    localparam pins_t BLUE_SHIFT  = {4'd0, 6'b001000, 3'b100};

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [BASE_W-1:0]     cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  req_type     = REQ_PIXEL;
    logic [4:0]            pix_x        = '0;
    logic [3:0]            pix_y        = '0;
    logic [RGB_W-1:0]      pix_rgb      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [ROW_ADDR_W-1:0] row_addr;
    logic                  red_top;
    logic                  green_top;
    logic                  blue_top;
    logic                  red_bottom;
    logic                  green_bottom;
    logic                  blue_bottom;
    logic                  shift_clock;
    logic                  latch_strobe;
    logic                  display_on;

    // scan sequencer mirror
    logic [23:0]       panel_frame [512] = '{default: '0};
    logic [1:0]        seq_scan     = '0;
    logic              seq_half     = 1'b0;
    logic [2:0]        seq_plane    = '0;
    logic [5:0]        seq_col      = '0;
    phase_t            seq_phase    = PH_SHIFT;
    logic [23:0]       seq_on_ticks = '0;
    logic [BASE_W-1:0] seq_base     = BASE_ON_RESET;

    pins_t pending_pins [$];
    int    fail_count   = 0;
    int    quiet_cycles = 0;
    bit    gaps_on      = 1'b1;

    // opening pattern: column words 1..3 of scan row 0 get one colour bit each
    step_row_t opening [22] = '{
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b1, BLANK_SHIFT},
        '{REQ_PIXEL, 5'd1,  4'd0,  24'h000001, 1'b0, NO_PINS},
        '{REQ_PIXEL, 5'd2,  4'd0,  24'h000100, 1'b0, NO_PINS},
        '{REQ_PIXEL, 5'd3,  4'd0,  24'h010000, 1'b0, NO_PINS},
        '{REQ_PIXEL, 5'd31, 4'd15, 24'hFFFFFF, 1'b0, NO_PINS},
        '{REQ_PIXEL, 5'd0,  4'd0,  24'hFFFFFF, 1'b0, NO_PINS},
        '{REQ_TICK,  5'd31, 4'd15, 24'hFFFFFF, 1'b1, RED_SHIFT},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b1, GREEN_SHIFT},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b1, BLUE_SHIFT},
        '{REQ_PIXEL, 5'd4,  4'd4,  24'hFFFFFF, 1'b0, NO_PINS},
        '{REQ_PIXEL, 5'd4,  4'd0,  24'hFFFFFE, 1'b0, NO_PINS},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b0, NO_PINS},
        '{REQ_PIXEL, 5'd8,  4'd0,  24'hFFFFFF, 1'b0, NO_PINS},
        '{REQ_PIXEL, 5'd5,  4'd8,  24'hFFFFFF, 1'b0, NO_PINS},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b1, BLANK_SHIFT},
        '{REQ_PIXEL, 5'd6,  4'd1,  24'hFFFFFF, 1'b0, NO_PINS},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b1, BLANK_SHIFT},
        '{REQ_PIXEL, 5'd16, 4'd12, 24'h123456, 1'b0, NO_PINS},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b0, NO_PINS},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b0, NO_PINS},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b0, NO_PINS},
        '{REQ_TICK,  5'd0,  4'd0,  24'h000000, 1'b0, NO_PINS}
    };

    led_matrix_bcm_scan_driver u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .pix_rgb      (pix_rgb),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_addr     (row_addr),
        .red_top      (red_top),
        .green_top    (green_top),
        .blue_top     (blue_top),
        .red_bottom   (red_bottom),
        .green_bottom (green_bottom),
        .blue_bottom  (blue_bottom),
        .shift_clock  (shift_clock),
        .latch_strobe (latch_strobe),
        .display_on   (display_on)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Pixel writes update the frame mirror and give 0; ticks give 1 and the pins.
    function automatic bit predict_pins(input logic kind, input logic [4:0] x,
                                        input logic [3:0] y, input logic [23:0] rgb,
                                        output pins_t p);
        logic [23:0] word;
        logic [23:0] span;
        p = '0;
        if (kind == REQ_PIXEL)
        begin
            // {half, scan, group, upper/lower row group, x mod 8}
            panel_frame[{y[3], y[1:0], x[4:3], y[2], x[2:0]}] = rgb;
            return 1'b0;
        end
        p.row = {2'b00, seq_scan};
        case (seq_phase)
            PH_SHIFT:
            begin
                word = panel_frame[{seq_half, seq_scan, seq_col}];
                if (seq_half)
                    {p.r_b, p.g_b, p.b_b} = {word[seq_plane], word[8 + seq_plane],
                                             word[16 + seq_plane]};
                else
                    {p.r_t, p.g_t, p.b_t} = {word[seq_plane], word[8 + seq_plane],
                                             word[16 + seq_plane]};
                p.shift = 1'b1;
                seq_col = seq_col + 6'd1;
                if (seq_col == 6'd0)
                    seq_phase = PH_LATCH;
            end
            PH_LATCH:
            begin
                p.latch      = 1'b1;
                seq_on_ticks = '0;
                seq_phase    = PH_SHOW;
            end
            default:
            begin
                span = (seq_base == '0) ? 24'd1 : 24'(seq_base);
                span = span << seq_plane;
                p.disp = 1'b1;
                seq_on_ticks = seq_on_ticks + 24'd1;
                if (seq_on_ticks >= span)
                begin
                    seq_on_ticks = '0;
                    seq_phase    = PH_SHIFT;
                    seq_plane    = seq_plane + 3'd1;
                    if (seq_plane == 3'd0)
                    begin
                        seq_half = ~seq_half;
                        if (!seq_half)
                            seq_scan = seq_scan + 2'd1;
                    end
                end
            end
        endcase
        return 1'b1;
    endfunction

    task automatic issue(input logic kind, input logic [4:0] x, input logic [3:0] y,
                         input logic [23:0] rgb, input logic typed, input pins_t pins);
        pins_t want;
        bit    made;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        pix_x    <= x;
        pix_y    <= y;
        pix_rgb  <= rgb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        made = predict_pins(kind, x, y, rgb, want);
        if (made)
            pending_pins.push_back(typed ? pins : want);
    endtask

    task automatic random_item(input int tick_pct);
        issue(($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_PIXEL,
              5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
              24'($urandom()), 1'b0, NO_PINS);
    endtask

    task automatic run_random(input int count, input int tick_pct);
        repeat (count)
            random_item(tick_pct);
    endtask

    // base time changes only with nothing in flight
    task automatic write_base(input logic [BASE_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        seq_base = value;
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pins_t want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pins.size() == 0)
            begin
                $error("pin vector with no tick request waiting");
                fail_count++;
            end
            else
            begin
                want = pending_pins.pop_front();
                check_field("row_addr", want.row, row_addr);
                check_field("red_top", 4'(want.r_t), 4'(red_top));
                check_field("green_top", 4'(want.g_t), 4'(green_top));
                check_field("blue_top", 4'(want.b_t), 4'(blue_top));
                check_field("red_bottom", 4'(want.r_b), 4'(red_bottom));
                check_field("green_bottom", 4'(want.g_b), 4'(green_bottom));
                check_field("blue_bottom", 4'(want.b_b), 4'(blue_bottom));
                check_field("shift_clock", 4'(want.shift), 4'(shift_clock));
                check_field("latch_strobe", 4'(want.latch), 4'(latch_strobe));
                check_field("display_on", 4'(want.disp), 4'(display_on));
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        forever
        begin
            if (gaps_on && rst_n && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("led_matrix_bcm_scan_driver: mismatch");
        $finish;
    end

    initial
    begin
        int k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset base time of 5
        for (k = 0; k < $size(opening); k++)
            issue(opening[k].kind, opening[k].x, opening[k].y, opening[k].rgb,
                  opening[k].typed, opening[k].pins);
        run_random(100, 85);

        // zero acts as one
        write_base(16'd0);
        run_random(250, 90);

        // hold a plane on screen, then cut the base time below what has elapsed
        write_base(16'hFFFF);
        while (!(seq_phase == PH_SHOW && seq_on_ticks >= (24'd1 << seq_plane) + 24'd2))
            random_item(90);
        write_base(16'd1);
        run_random(350, 90);

        gaps_on = 1'b0;
        run_random(200, 90);

        in_valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("led_matrix_bcm_scan_driver: match");
        else
            $display("led_matrix_bcm_scan_driver: mismatch");
        $finish;
    end

endmodule
